// File: sv/cpt_pkg.sv
// Shared types and constants for the phase current Park transform unit.
package cpt_pkg;

  localparam int CUR_W  = 21;
  localparam int DQ_W   = 22;
  localparam int PH_W   = 22;
  localparam int TRIG_W = 16;

  localparam int OFFSET_W = 12;
  localparam int GAIN_W   = 16;
  localparam int POLE_W   = 7;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ADC_OFFSET   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLE_PAIRS   = 2'd2;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd2048;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd13517;
  localparam logic [POLE_W-1:0]   POLE_RESET   = 7'd7;

  localparam logic signed [CUR_W-1:0] CUR_MAX = 21'sd1048575;
  localparam logic signed [CUR_W-1:0] CUR_MIN = -21'sd1048576;
  localparam logic signed [DQ_W-1:0]  DQ_MAX  = 22'sd2097151;
  localparam logic signed [DQ_W-1:0]  DQ_MIN  = -22'sd2097152;

  // Common-mode mean: floor((sum + 1) / 3) through a biased reciprocal multiply.
  localparam int MEAN_U_W     = 23;
  localparam int MEAN_RECIP_W = 24;
  localparam int MEAN_SHIFT   = 25;
  localparam int MEAN_P_W     = MEAN_U_W + MEAN_RECIP_W;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = 24'd11184811;
  localparam logic signed [MEAN_U_W:0] MEAN_BIAS = 24'sd3145729;
  localparam logic signed [PH_W-1:0]   MEAN_UNBIAS = 22'sd1048576;

  // Sine and cosine generation.
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 33;
  localparam int RESID_W      = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [CORDIC_W-1:0] TRIG_ROUND = 33'sd16384;
  localparam int TRIG_SHIFT = 15;
  localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd32767;
  localparam logic [31:0] THIRD_TURN = 32'h5555_5555;
  localparam logic [31:0] PHASE_BIAS = 32'h2000_0000;

  localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10680862,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
  };

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // d/q scaling: floor((acc + 24576) / 49152) as a shift by 14 and a divide by 3.
  localparam int ACC_W       = 40;
  localparam int DQ_PRE_SHIFT = 14;
  localparam int DQ_N_W      = ACC_W - DQ_PRE_SHIFT;
  localparam int DQ_U_W      = 26;
  localparam int DQ_RECIP_W  = 28;
  localparam int DQ_SHIFT    = 29;
  localparam int DQ_P_W      = DQ_U_W + DQ_RECIP_W;
  localparam logic signed [ACC_W-1:0]   DQ_ROUND = 40'sd24576;
  localparam logic signed [DQ_N_W+1:0]  DQ_BIAS  = 28'sd50331648;
  localparam logic [DQ_RECIP_W-1:0]     DQ_RECIP = 28'd178956971;
  localparam int DQ_R_W = DQ_P_W - DQ_SHIFT + 1;
  localparam logic signed [DQ_R_W-1:0]  DQ_UNBIAS = 26'sd16777216;

  // Stages from input to the last datapath register.
  localparam int ALIGN_STAGES = CORDIC_STEPS - 3;
  localparam int PIPE_STAGES  = CORDIC_STEPS + 8;

  localparam int OUT_TDATA_W = ((3 * CUR_W + 2 * DQ_W + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0]                quad;
    logic signed [RESID_W-1:0] resid;
  } phase_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } trig_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] cur_a;
    logic signed [CUR_W-1:0] cur_b;
    logic signed [CUR_W-1:0] cur_c;
    logic signed [PH_W-1:0]  ph_a;
    logic signed [PH_W-1:0]  ph_b;
    logic signed [PH_W-1:0]  ph_c;
  } meas_t;

  // The last field sits in the lowest bits.
  typedef struct packed {
    logic signed [DQ_W-1:0]  q_current;
    logic signed [DQ_W-1:0]  d_current;
    logic signed [CUR_W-1:0] current_c;
    logic signed [CUR_W-1:0] current_b;
    logic signed [CUR_W-1:0] current_a;
  } result_t;

endpackage

// File: sv/phase_current_park_transform_unit.sv
// Top level of the phase current Park transform unit.
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    adc_a, adc_b, adc_c, mech_angle
//  m_*       out        m_tvalid / m_tready    current_a/b/c, d_current, q_current
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample set is taken every cycle while s_tready is high; its result reaches
// m_tdata through 25 register stages: two for the angle, the 16 CORDIC stages,
// one rounding stage, five d/q stages and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stalled output holds the result; one skid entry lets the pipeline take
// one more transaction before s_tready drops.
module phase_current_park_transform_unit #(
  parameter int ADC_BITS   = 12,
  parameter int ANGLE_BITS = 16,
  localparam int IN_TDATA_W = ((3 * ADC_BITS + ANGLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // adc_a, adc_b, adc_c, mech_angle, zero fill
  input  logic [IN_TDATA_W-1:0]             s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // current_a, current_b, current_c, d_current, q_current, zero fill
  output logic [cpt_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [cpt_pkg::OFFSET_W-1:0] adc_offset;
  logic [cpt_pkg::GAIN_W-1:0]   current_gain;
  logic [cpt_pkg::POLE_W-1:0]   pole_pairs;
  logic                         en;
  logic                         vld [cpt_pkg::PIPE_STAGES];
  logic                         skid_valid;
  cpt_pkg::result_t             skid_data;
  cpt_pkg::result_t             out_data;
  cpt_pkg::result_t             pipe_data;
  cpt_pkg::phase_t              lane [3];
  cpt_pkg::trig_t               trig [3];
  cpt_pkg::meas_t               meas;

  assign en        = !skid_valid;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tdata   = cpt_pkg::OUT_TDATA_W'(out_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset   <= cpt_pkg::OFFSET_RESET;
      current_gain <= cpt_pkg::GAIN_RESET;
      pole_pairs   <= cpt_pkg::POLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpt_pkg::CFG_ADC_OFFSET:   adc_offset   <= cfg_data[cpt_pkg::OFFSET_W-1:0];
        cpt_pkg::CFG_CURRENT_GAIN: current_gain <= cfg_data[cpt_pkg::GAIN_W-1:0];
        cpt_pkg::CFG_POLE_PAIRS:   pole_pairs   <= cfg_data[cpt_pkg::POLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpt_pkg::PIPE_STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < cpt_pkg::PIPE_STAGES; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  cpt_current #(
    .ADC_BITS(ADC_BITS)
  ) u_current (
    .clk(clk),
    .en(en),
    .adc_a(s_tdata[0 +: ADC_BITS]),
    .adc_b(s_tdata[ADC_BITS +: ADC_BITS]),
    .adc_c(s_tdata[2*ADC_BITS +: ADC_BITS]),
    .adc_offset(adc_offset),
    .current_gain(current_gain),
    .meas(meas)
  );

  cpt_phase #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_phase (
    .clk(clk),
    .en(en),
    .mech_angle(s_tdata[3*ADC_BITS +: ANGLE_BITS]),
    .pole_pairs(pole_pairs),
    .lane(lane)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cpt_cordic u_cordic (
      .clk(clk),
      .en(en),
      .lane_in(lane[k]),
      .trig(trig[k])
    );
  end

  cpt_dq u_dq (
    .clk(clk),
    .en(en),
    .trig(trig),
    .meas(meas),
    .result(pipe_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= vld[cpt_pkg::PIPE_STAGES-1];
      end else if (vld[cpt_pkg::PIPE_STAGES-1]) begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid   <= 1'b1;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_tvalid || m_tready) begin
        out_data <= pipe_data;
      end else begin
        skid_data <= pipe_data;
      end
    end else if (m_tready) begin
      out_data <= skid_data;
    end
  end

endmodule

// File: sv/cpt_current.sv
// Phase current scaling, common-mode removal and alignment delay line.
module cpt_current #(
  parameter int ADC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ADC_BITS-1:0]           adc_a,
  input  logic [ADC_BITS-1:0]           adc_b,
  input  logic [ADC_BITS-1:0]           adc_c,
  input  logic [cpt_pkg::OFFSET_W-1:0]  adc_offset,
  input  logic [cpt_pkg::GAIN_W-1:0]    current_gain,
  output cpt_pkg::meas_t                meas
);

  localparam int DIFF_W = ADC_BITS + 1;
  localparam int PROD_W = DIFF_W + cpt_pkg::GAIN_W + 1;
  localparam int RND_W  = PROD_W + 1;
  localparam int SCL_W  = RND_W - 8;
  localparam int CMP_W  = RND_W + cpt_pkg::CUR_W;
  localparam int SUM_W  = cpt_pkg::CUR_W + 2;

  logic [ADC_BITS+cpt_pkg::OFFSET_W-1:0] offset_wide;
  logic [ADC_BITS-1:0]                   offset_cut;
  logic [ADC_BITS-1:0]                   adc [3];
  logic signed [DIFF_W-1:0]              diff [3];
  logic signed [PROD_W-1:0]              prod [3];
  logic signed [RND_W-1:0]               prod_round [3];
  logic signed [SCL_W-1:0]               scaled [3];
  logic signed [cpt_pkg::CUR_W-1:0]      cur_sat [3];
  logic signed [cpt_pkg::CUR_W-1:0]      cur3 [3];
  logic signed [cpt_pkg::CUR_W-1:0]      cur4 [3];
  logic signed [cpt_pkg::CUR_W-1:0]      cur5 [3];
  logic signed [SUM_W-1:0]               sum;
  logic signed [cpt_pkg::MEAN_U_W:0]     biased;
  logic [cpt_pkg::MEAN_U_W-1:0]          mean_u;
  logic [cpt_pkg::MEAN_P_W-1:0]          mean_prod;
  logic signed [cpt_pkg::PH_W-1:0]       mean;
  cpt_pkg::meas_t                        meas6;
  cpt_pkg::meas_t                        line [cpt_pkg::ALIGN_STAGES];

  assign offset_wide = {{ADC_BITS{1'b0}}, adc_offset};
  assign offset_cut  = offset_wide[ADC_BITS-1:0];
  assign adc[0] = adc_a;
  assign adc[1] = adc_b;
  assign adc[2] = adc_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_round[k] = RND_W'(prod[k]) + RND_W'(128);
      scaled[k]     = $signed(prod_round[k][RND_W-1:8]);
      if (CMP_W'(scaled[k]) > CMP_W'(cpt_pkg::CUR_MAX)) begin
        cur_sat[k] = cpt_pkg::CUR_MAX;
      end else if (CMP_W'(scaled[k]) < CMP_W'(cpt_pkg::CUR_MIN)) begin
        cur_sat[k] = cpt_pkg::CUR_MIN;
      end else begin
        cur_sat[k] = cpt_pkg::CUR_W'(scaled[k]);
      end
    end
    sum    = SUM_W'(cur3[0]) + SUM_W'(cur3[1]) + SUM_W'(cur3[2]);
    biased = (cpt_pkg::MEAN_U_W + 1)'(sum) + cpt_pkg::MEAN_BIAS;
    mean   = $signed(mean_prod[cpt_pkg::MEAN_P_W-1:cpt_pkg::MEAN_SHIFT]) - cpt_pkg::MEAN_UNBIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        diff[k] <= $signed({1'b0, adc[k]}) - $signed({1'b0, offset_cut});
        prod[k] <= PROD_W'(diff[k]) * PROD_W'($signed({1'b0, current_gain}));
        cur3[k] <= cur_sat[k];
        cur4[k] <= cur3[k];
        cur5[k] <= cur4[k];
      end
      mean_u    <= biased[cpt_pkg::MEAN_U_W-1:0];
      mean_prod <= cpt_pkg::MEAN_P_W'(mean_u) * cpt_pkg::MEAN_P_W'(cpt_pkg::MEAN_RECIP);
      meas6.cur_a <= cur5[0];
      meas6.cur_b <= cur5[1];
      meas6.cur_c <= cur5[2];
      meas6.ph_a  <= cpt_pkg::PH_W'(cur5[0]) - mean;
      meas6.ph_b  <= cpt_pkg::PH_W'(cur5[1]) - mean;
      meas6.ph_c  <= cpt_pkg::PH_W'(cur5[2]) - mean;
      line[0] <= meas6;
      for (int i = 1; i < cpt_pkg::ALIGN_STAGES; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign meas = line[cpt_pkg::ALIGN_STAGES-1];

endmodule

// File: sv/cpt_phase.sv
// Electrical angle and the three phase-shifted quadrant/residual pairs.
module cpt_phase #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       mech_angle,
  input  logic [cpt_pkg::POLE_W-1:0]  pole_pairs,
  output cpt_pkg::phase_t             lane [3]
);

  logic [ANGLE_BITS+cpt_pkg::POLE_W-1:0] angle_prod;
  logic [ANGLE_BITS-1:0]                 elec;
  logic [31:0]                           phase_base;
  logic [31:0]                           phase [3];
  logic [31:0]                           shifted [3];

  always_comb begin
    angle_prod = (ANGLE_BITS + cpt_pkg::POLE_W)'(mech_angle) *
                 (ANGLE_BITS + cpt_pkg::POLE_W)'(pole_pairs);
    phase_base = {elec, {(32 - ANGLE_BITS){1'b0}}};
    phase[0]   = phase_base;
    phase[1]   = phase_base - cpt_pkg::THIRD_TURN;
    phase[2]   = phase_base + cpt_pkg::THIRD_TURN;
    for (int k = 0; k < 3; k++) begin
      shifted[k] = phase[k] + cpt_pkg::PHASE_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elec <= angle_prod[ANGLE_BITS-1:0];
      for (int k = 0; k < 3; k++) begin
        lane[k].quad  <= shifted[k][31:30];
        lane[k].resid <= $signed({~shifted[k][29], shifted[k][28:0]});
      end
    end
  end

endmodule

// File: sv/cpt_cordic.sv
// Pipelined rotation-mode CORDIC giving Q1.15 cosine and sine for one phase.
module cpt_cordic (
  input  logic            clk,
  input  logic            en,
  input  cpt_pkg::phase_t lane_in,
  output cpt_pkg::trig_t  trig
);

  localparam int W = cpt_pkg::CORDIC_W;
  localparam int N = cpt_pkg::CORDIC_STEPS;

  logic signed [W-1:0] x [N];
  logic signed [W-1:0] y [N];
  logic signed [W-1:0] z [N];
  logic [1:0]          quad [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] xi;
    logic signed [W-1:0] yi;
    logic signed [W-1:0] zi;
    logic [1:0]          qi;

    if (i == 0) begin : g_first
      assign xi = cpt_pkg::CORDIC_K;
      assign yi = '0;
      assign zi = W'(lane_in.resid);
      assign qi = lane_in.quad;
    end else begin : g_next
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign zi = z[i-1];
      assign qi = quad[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quad[i] <= qi;
        if (!zi[W-1]) begin
          x[i] <= xi - (yi >>> i);
          y[i] <= yi + (xi >>> i);
          z[i] <= zi - cpt_pkg::ATAN_TURNS[i];
        end else begin
          x[i] <= xi + (yi >>> i);
          y[i] <= yi - (xi >>> i);
          z[i] <= zi + cpt_pkg::ATAN_TURNS[i];
        end
      end
    end
  end

  logic signed [W-1:0]              xr;
  logic signed [W-1:0]              yr;
  logic signed [cpt_pkg::TRIG_W-1:0] c_sat;
  logic signed [cpt_pkg::TRIG_W-1:0] s_sat;
  cpt_pkg::trig_t                   rotated;

  always_comb begin
    xr = (x[N-1] + cpt_pkg::TRIG_ROUND) >>> cpt_pkg::TRIG_SHIFT;
    yr = (y[N-1] + cpt_pkg::TRIG_ROUND) >>> cpt_pkg::TRIG_SHIFT;
    if (xr > W'(cpt_pkg::TRIG_MAX)) begin
      c_sat = cpt_pkg::TRIG_MAX;
    end else if (xr < -W'(cpt_pkg::TRIG_MAX)) begin
      c_sat = -cpt_pkg::TRIG_MAX;
    end else begin
      c_sat = cpt_pkg::TRIG_W'(xr);
    end
    if (yr > W'(cpt_pkg::TRIG_MAX)) begin
      s_sat = cpt_pkg::TRIG_MAX;
    end else if (yr < -W'(cpt_pkg::TRIG_MAX)) begin
      s_sat = -cpt_pkg::TRIG_MAX;
    end else begin
      s_sat = cpt_pkg::TRIG_W'(yr);
    end
    case (quad[N-1])
      cpt_pkg::QUAD_0: begin
        rotated.cos_val = c_sat;
        rotated.sin_val = s_sat;
      end
      cpt_pkg::QUAD_1: begin
        rotated.cos_val = -s_sat;
        rotated.sin_val = c_sat;
      end
      cpt_pkg::QUAD_2: begin
        rotated.cos_val = -c_sat;
        rotated.sin_val = -s_sat;
      end
      default: begin
        rotated.cos_val = s_sat;
        rotated.sin_val = -c_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig <= rotated;
    end
  end

endmodule

// File: sv/cpt_dq.sv
// Park transform products, accumulation and d/q scaling with saturation.
module cpt_dq (
  input  logic             clk,
  input  logic             en,
  input  cpt_pkg::trig_t   trig [3],
  input  cpt_pkg::meas_t   meas,
  output cpt_pkg::result_t result
);

  localparam int PROD_W = cpt_pkg::TRIG_W + cpt_pkg::PH_W;

  function automatic logic [cpt_pkg::DQ_U_W-1:0] dq_bias(
    input logic signed [cpt_pkg::ACC_W-1:0] n
  );
    logic signed [cpt_pkg::ACC_W-1:0]  t;
    logic signed [cpt_pkg::DQ_N_W-1:0] n1;
    logic signed [cpt_pkg::DQ_N_W+1:0] b;
    t  = n + cpt_pkg::DQ_ROUND;
    n1 = $signed(t[cpt_pkg::ACC_W-1:cpt_pkg::DQ_PRE_SHIFT]);
    b  = (cpt_pkg::DQ_N_W + 2)'(n1) + cpt_pkg::DQ_BIAS;
    return b[cpt_pkg::DQ_U_W-1:0];
  endfunction

  function automatic logic signed [cpt_pkg::DQ_W-1:0] dq_sat(
    input logic [cpt_pkg::DQ_P_W-1:0] p
  );
    logic signed [cpt_pkg::DQ_R_W-1:0] r;
    r = $signed({1'b0, p[cpt_pkg::DQ_P_W-1:cpt_pkg::DQ_SHIFT]}) - cpt_pkg::DQ_UNBIAS;
    if (r > cpt_pkg::DQ_R_W'(cpt_pkg::DQ_MAX)) begin
      return cpt_pkg::DQ_MAX;
    end else if (r < cpt_pkg::DQ_R_W'(cpt_pkg::DQ_MIN)) begin
      return cpt_pkg::DQ_MIN;
    end
    return cpt_pkg::DQ_W'(r);
  endfunction

  logic signed [cpt_pkg::PH_W-1:0]  ph [3];
  logic signed [PROD_W-1:0]         pc [3];
  logic signed [PROD_W-1:0]         ps [3];
  logic signed [cpt_pkg::ACC_W-1:0] acc_c;
  logic signed [cpt_pkg::ACC_W-1:0] acc_s;
  logic [cpt_pkg::DQ_U_W-1:0]       u_d;
  logic [cpt_pkg::DQ_U_W-1:0]       u_q;
  logic [cpt_pkg::DQ_P_W-1:0]       p_d;
  logic [cpt_pkg::DQ_P_W-1:0]       p_q;
  cpt_pkg::meas_t                   meas_r [4];

  assign ph[0] = meas.ph_a;
  assign ph[1] = meas.ph_b;
  assign ph[2] = meas.ph_c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pc[k] <= PROD_W'(trig[k].cos_val) * PROD_W'(ph[k]);
        ps[k] <= PROD_W'(trig[k].sin_val) * PROD_W'(ph[k]);
      end
      acc_c <= cpt_pkg::ACC_W'(pc[0]) + cpt_pkg::ACC_W'(pc[1]) + cpt_pkg::ACC_W'(pc[2]);
      acc_s <= cpt_pkg::ACC_W'(ps[0]) + cpt_pkg::ACC_W'(ps[1]) + cpt_pkg::ACC_W'(ps[2]);
      u_d   <= dq_bias(acc_c);
      u_q   <= dq_bias(-acc_s);
      p_d   <= cpt_pkg::DQ_P_W'(u_d) * cpt_pkg::DQ_P_W'(cpt_pkg::DQ_RECIP);
      p_q   <= cpt_pkg::DQ_P_W'(u_q) * cpt_pkg::DQ_P_W'(cpt_pkg::DQ_RECIP);
      meas_r[0] <= meas;
      for (int i = 1; i < 4; i++) begin
        meas_r[i] <= meas_r[i-1];
      end
      result.current_a <= meas_r[3].cur_a;
      result.current_b <= meas_r[3].cur_b;
      result.current_c <= meas_r[3].cur_c;
      result.d_current <= dq_sat(p_d);
      result.q_current <= dq_sat(p_q);
    end
  end

endmodule

// File: sv/cpt_checker.sv
// Port-level checks for the phase current Park transform unit, with its bind.
module cpt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cpt_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Output transaction changed while stalled.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("Input stalled without output back-pressure.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("Reset did not clear the pipeline.");

endmodule

bind phase_current_park_transform_unit cpt_checker u_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
